@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL of the WAV header parser.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on clk, disabled while the active-low reset is held.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_AT(lbl, clk, rstn, !(cond), msg)

`endif

@@ hdl/whp_pkg.sv @@
// Types and constants of the WAV header parser.
// Depends on nothing; imported by wav_header_parser, whp_checker and tb.
`default_nettype none

package whp_pkg;

    // Report codes, in order of priority for the format chunk checks.
    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_TRUNC     = 4'd1,
        ST_RIFF      = 4'd2,
        ST_WAVEFMT   = 4'd3,
        ST_TOTAL     = 4'd4,
        ST_TAG       = 4'd5,
        ST_CHANNELS  = 4'd6,
        ST_RATE      = 4'd7,
        ST_BITS      = 4'd8,
        ST_FMT_EXT   = 4'd9,
        ST_DATA_SIG  = 4'd10,
        ST_DATA_SIZE = 4'd11
    } status_t;

    localparam int MAX_EXTENSION_DEFAULT = 20;

    // Signatures stored little-endian: byte k sits at bits [8k+7:8k].
    localparam logic [31:0] RIFF_MAGIC    = 32'h4646_4952;           // "RIFF"
    localparam logic [63:0] WAVEFMT_MAGIC = 64'h2074_6D66_4556_4157; // "WAVEfmt "
    localparam logic [31:0] DATA_MAGIC    = 32'h6174_6164;           // "data"

    localparam logic [31:0] SIZE_MIN    = 32'd44;
    localparam logic [31:0] SIZE_LIMIT  = 32'd50_000_000;
    localparam logic [31:0] RATE_MIN    = 32'd1000;
    localparam logic [31:0] RATE_MAX    = 32'd1_000_000;
    localparam logic [31:0] FMT_BASE    = 32'd16;
    localparam logic [15:0] TAG_PCM     = 16'd1;
    localparam logic [15:0] CH_MONO     = 16'd1;
    localparam logic [15:0] CH_STEREO   = 16'd2;
    localparam logic [15:0] BITS_8      = 16'd8;
    localparam logic [15:0] BITS_16     = 16'd16;

    // Byte offsets in the file.
    localparam int          POS_W        = 6;
    localparam logic [5:0]  POS_RIFF_SZ  = 6'd4;
    localparam logic [5:0]  POS_WAVEFMT  = 6'd8;
    localparam logic [5:0]  POS_FMT_SZ   = 6'd16;
    localparam logic [5:0]  POS_TAG      = 6'd20;
    localparam logic [5:0]  POS_CHAN     = 6'd22;
    localparam logic [5:0]  POS_RATE     = 6'd24;
    localparam logic [5:0]  POS_RATE_END = 6'd28;
    localparam logic [5:0]  POS_BITS     = 6'd34;
    localparam logic [5:0]  POS_HDR_LAST = 6'd35;
    localparam logic [5:0]  POS_TAIL     = 6'd36;
    localparam logic [5:0]  POS_DSIZE    = 6'd40;
    localparam logic [5:0]  POS_LAST     = 6'd43;

    // Result transaction layout.
    localparam int RES_W      = 57;
    localparam int M_TDATA_W  = 64;

endpackage

`default_nettype wire

@@ hdl/wav_header_parser.sv @@
// WAV header parser: checks a RIFF/WAVE PCM header one byte per cycle unless stalled.
// Depends on whp_pkg and assert_macros.svh.
//
//  Channel | Ports                              | Contents (lowest bit first)
//  --------+------------------------------------+-------------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser  | tdata: data_byte[7:0]; tuser: first_byte;
//          | s_tlast                            | tlast: end_of_stream
//  result  | m_tvalid m_tready m_tdata          | tdata: status[3:0], channel_count[5:4],
//          |                                    | sample_rate[25:6], sample_bits[30:26],
//          |                                    | payload_bytes[56:31], zeros to bit 63
//
// Every byte is judged in the cycle that accepts it; the parser can accept a byte on
// every clock while s_tready is high. Each report is registered as its byte is accepted.
// The result side has an output register plus one skid register, so bytes keep flowing
// while one report waits; s_tready drops only while both hold a report.
// Reset (aresetn low, synchronous) returns the parser to idle and empties both registers.
// In idle, bytes without the first-byte flag are consumed and produce no report.
`include "assert_macros.svh"
`default_nettype none

module wav_header_parser
    import whp_pkg::*;
#(
    parameter int MAX_EXTENSION = MAX_EXTENSION_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // data_byte[7:0]
    input  wire logic                 s_tuser,   // first_byte
    input  wire logic                 s_tlast,   // end_of_stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // status, channel_count, sample_rate,
                                                 // sample_bits, payload_bytes, zero fill
);

    // Extension counter holds 0..MAX_EXTENSION; at least one bit.
    localparam int EXT_W = $clog2(MAX_EXTENSION + 2);
    localparam logic [31:0] FMT_MAX = FMT_BASE + 32'(MAX_EXTENSION);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_EXT,
        PH_TAIL
    } phase_t;

    // Parser state.
    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               riff_ok_reg, riff_ok_next;
    logic               fmt_ok_reg, fmt_ok_next;
    logic               data_ok_reg, data_ok_next;
    logic [31:0]        riff_size_reg, riff_size_next;
    logic [31:0]        fmt_size_reg, fmt_size_next;
    logic [15:0]        tag_reg, tag_next;
    logic [15:0]        chan_reg, chan_next;
    logic [31:0]        rate_reg, rate_next;
    logic [15:0]        bits_reg, bits_next;
    logic [EXT_W-1:0]   ext_left_reg, ext_left_next;
    logic [31:0]        dsize_reg, dsize_next;

    // Result registers.
    logic               out_valid_reg;
    logic [RES_W-1:0]   out_data_reg;
    logic               skid_valid_reg;
    logic [RES_W-1:0]   skid_data_reg;

    logic               accept;
    logic               res_valid;
    status_t            res_status;
    status_t            hdr_status;
    logic [RES_W-1:0]   res_data;
    phase_t             cur_phase;
    logic [POS_W-1:0]   cur_pos;
    logic [7:0]         b;
    logic [31:0]        ext_full;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, out_data_reg};

    always_comb begin
        // A first byte restarts the parser regardless of where it stood.
        cur_phase      = s_tuser ? PH_HEADER : phase_reg;
        cur_pos        = s_tuser ? '0 : pos_reg;
        riff_ok_next   = s_tuser ? 1'b1 : riff_ok_reg;
        fmt_ok_next    = s_tuser ? 1'b1 : fmt_ok_reg;
        data_ok_next   = data_ok_reg;
        phase_next     = cur_phase;
        pos_next       = cur_pos;
        riff_size_next = riff_size_reg;
        fmt_size_next  = fmt_size_reg;
        tag_next       = tag_reg;
        chan_next      = chan_reg;
        rate_next      = rate_reg;
        bits_next      = bits_reg;
        ext_left_next  = ext_left_reg;
        dsize_next     = dsize_reg;
        res_valid      = 1'b0;
        res_status     = ST_OK;
        hdr_status     = ST_OK;
        ext_full       = '0;

        unique case (cur_phase)
            PH_IDLE: begin
            end
            PH_HEADER: begin
                // Fields are cleared by being written byte by byte before they are judged.
                priority if (cur_pos < POS_RIFF_SZ) begin
                    if (b != RIFF_MAGIC[8*cur_pos[1:0] +: 8]) begin
                        riff_ok_next = 1'b0;
                    end
                end else if (cur_pos < POS_WAVEFMT) begin
                    riff_size_next[8*cur_pos[1:0] +: 8] = b;
                end else if (cur_pos < POS_FMT_SZ) begin
                    if (b != WAVEFMT_MAGIC[8*cur_pos[2:0] +: 8]) begin
                        fmt_ok_next = 1'b0;
                    end
                end else if (cur_pos < POS_TAG) begin
                    fmt_size_next[8*cur_pos[1:0] +: 8] = b;
                end else if (cur_pos < POS_CHAN) begin
                    tag_next[8*cur_pos[0] +: 8] = b;
                end else if (cur_pos < POS_RATE) begin
                    chan_next[8*cur_pos[0] +: 8] = b;
                end else if (cur_pos < POS_RATE_END) begin
                    rate_next[8*cur_pos[1:0] +: 8] = b;
                end else if (cur_pos >= POS_BITS) begin
                    bits_next[8*cur_pos[0] +: 8] = b;
                end else begin
                end

                // Header checks are judged together, on the field values including this byte.
                priority if (!riff_ok_next) begin
                    hdr_status = ST_RIFF;
                end else if (!fmt_ok_next) begin
                    hdr_status = ST_WAVEFMT;
                end else if (riff_size_next < SIZE_MIN || riff_size_next > SIZE_LIMIT) begin
                    hdr_status = ST_TOTAL;
                end else if (tag_next != TAG_PCM) begin
                    hdr_status = ST_TAG;
                end else if (chan_next != CH_MONO && chan_next != CH_STEREO) begin
                    hdr_status = ST_CHANNELS;
                end else if (rate_next < RATE_MIN || rate_next > RATE_MAX) begin
                    hdr_status = ST_RATE;
                end else if (bits_next != BITS_8 && bits_next != BITS_16) begin
                    hdr_status = ST_BITS;
                end else if (fmt_size_next > FMT_MAX) begin
                    hdr_status = ST_FMT_EXT;
                end else begin
                    hdr_status = ST_OK;
                end

                pos_next = cur_pos + 1'b1;
                if (cur_pos == POS_HDR_LAST) begin
                    // The header is judged before truncation is considered.
                    if (hdr_status != ST_OK) begin
                        res_valid  = 1'b1;
                        res_status = hdr_status;
                        phase_next = PH_IDLE;
                    end else begin
                        // The format size has passed its check, so the extension fits.
                        ext_full      = fmt_size_next - FMT_BASE;
                        ext_left_next = (fmt_size_next > FMT_BASE) ? ext_full[EXT_W-1:0] : '0;
                        pos_next      = POS_TAIL;
                        data_ok_next  = 1'b1;
                        phase_next    = (ext_left_next != '0) ? PH_EXT : PH_TAIL;
                    end
                end
                if (s_tlast && !res_valid) begin
                    res_valid  = 1'b1;
                    res_status = ST_TRUNC;
                    phase_next = PH_IDLE;
                end
            end
            PH_EXT: begin
                // Extension bytes of the format chunk are skipped.
                if (ext_left_reg != '0) begin
                    ext_left_next = ext_left_reg - 1'b1;
                end
                if (ext_left_next == '0) begin
                    phase_next = PH_TAIL;
                end
                if (s_tlast) begin
                    res_valid  = 1'b1;
                    res_status = ST_TRUNC;
                    phase_next = PH_IDLE;
                end
            end
            PH_TAIL: begin
                if (cur_pos < POS_DSIZE) begin
                    if (b != DATA_MAGIC[8*cur_pos[1:0] +: 8]) begin
                        data_ok_next = 1'b0;
                    end
                end else begin
                    dsize_next[8*cur_pos[1:0] +: 8] = b;
                end
                pos_next = cur_pos + 1'b1;
                if (cur_pos >= POS_LAST) begin
                    res_valid  = 1'b1;
                    phase_next = PH_IDLE;
                    priority if (!data_ok_next) begin
                        res_status = ST_DATA_SIG;
                    end else if (dsize_next == '0 || dsize_next > SIZE_LIMIT) begin
                        res_status = ST_DATA_SIZE;
                    end else begin
                        res_status = ST_OK;
                    end
                end else if (s_tlast) begin
                    res_valid  = 1'b1;
                    res_status = ST_TRUNC;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        // Header values are reported only for a clean header.
        if (res_status == ST_OK) begin
            res_data = {dsize_next[25:0], bits_next[4:0], rate_next[19:0], chan_next[1:0],
                        res_status};
        end else begin
            res_data = {{(RES_W - 4){1'b0}}, res_status};
        end
    end

    // Parser state only moves on an accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            riff_ok_reg   <= 1'b1;
            fmt_ok_reg    <= 1'b1;
            data_ok_reg   <= 1'b1;
            ext_left_reg  <= '0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            riff_ok_reg   <= riff_ok_next;
            fmt_ok_reg    <= fmt_ok_next;
            data_ok_reg   <= data_ok_next;
            ext_left_reg  <= ext_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            riff_size_reg <= riff_size_next;
            fmt_size_reg  <= fmt_size_next;
            tag_reg       <= tag_next;
            chan_reg      <= chan_next;
            rate_reg      <= rate_next;
            bits_reg      <= bits_next;
            dsize_reg     <= dsize_next;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept && res_valid) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_data;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res_data;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    `ASSERT_AT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg,
        "skid entry holds a report while the output register is empty")
    `ASSERT_NEVER(a_idle_silent, aclk, aresetn,
        accept && !s_tuser && phase_reg == PH_IDLE && res_valid,
        "a byte taken in idle produced a report")
    `ASSERT_AT(a_last_reports, aclk, aresetn,
        (accept && s_tlast && (s_tuser || phase_reg != PH_IDLE)) |-> res_valid,
        "end of stream inside a file produced no report")
    `ASSERT_AT(a_report_idles, aclk, aresetn, (accept && res_valid) |=> phase_reg == PH_IDLE,
        "parser did not return to idle after a report")

endmodule

`default_nettype wire

@@ tb/whp_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the WAV header parser: watches both stream channels, follows the header
// in its own copy of the parser state and checks every report field by field.
// Depends on whp_pkg for the status codes, signatures and limits.

module whp_checker
    import whp_pkg::*;
#(
    parameter int MAX_EXT = MAX_EXTENSION_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // data_byte[7:0]
    input  logic                 s_tuser,   // first_byte
    input  logic                 s_tlast,   // end_of_stream
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // status, channel_count, sample_rate,
                                            // sample_bits, payload_bytes, zero fill
    output int                   fail_count,
    output int                   reports_waiting,
    output int                   reports_checked,
    output int                   headers_ok
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_EXT,
        PH_TAIL
    } parse_phase_t;

    typedef struct {
        status_t     status;
        logic [1:0]  channels;
        logic [19:0] rate;
        logic [4:0]  bits;
        logic [25:0] payload;
    } wav_report_t;

    parse_phase_t parse_phase;
    int unsigned  byte_pos;
    int unsigned  ext_left;
    logic         riff_sig_ok;
    logic         wave_sig_ok;
    logic         data_sig_ok;
    logic [31:0]  riff_len;
    logic [31:0]  fmt_len;
    logic [31:0]  tag_val;
    logic [31:0]  chan_val;
    logic [31:0]  rate_val;
    logic [31:0]  bits_val;
    logic [31:0]  data_len;

    wav_report_t  expected_reports[$];
    int           fails;
    int           checked;
    int           ok_count;

    function void reset_parser();
        parse_phase = PH_IDLE;
        byte_pos    = 0;
        ext_left    = 0;
        riff_sig_ok = 1'b1;
        wave_sig_ok = 1'b1;
        data_sig_ok = 1'b1;
        riff_len    = '0;
        fmt_len     = '0;
        tag_val     = '0;
        chan_val    = '0;
        rate_val    = '0;
        bits_val    = '0;
        data_len    = '0;
    endfunction

    // Places one byte of a little-endian field; offset counts from the field's first byte.
    function automatic logic [31:0] le_insert(logic [31:0] field, int offset, logic [7:0] b);
        return field | (32'(b) << (8 * (offset & 3)));
    endfunction

    // All format chunk checks are judged together, in order of the status codes.
    function automatic status_t header_verdict();
        if (!riff_sig_ok) return ST_RIFF;
        if (!wave_sig_ok) return ST_WAVEFMT;
        if (riff_len < SIZE_MIN || riff_len > SIZE_LIMIT) return ST_TOTAL;
        if (tag_val != 32'(TAG_PCM)) return ST_TAG;
        if (chan_val != 32'(CH_MONO) && chan_val != 32'(CH_STEREO)) return ST_CHANNELS;
        if (rate_val < RATE_MIN || rate_val > RATE_MAX) return ST_RATE;
        if (bits_val != 32'(BITS_8) && bits_val != 32'(BITS_16)) return ST_BITS;
        if (fmt_len > FMT_BASE && fmt_len - FMT_BASE > 32'(MAX_EXT)) return ST_FMT_EXT;
        return ST_OK;
    endfunction

    // Header values are only reported with a clean status; the parser then goes idle.
    function void queue_report(status_t st);
        wav_report_t rep;
        rep.status   = st;
        rep.channels = (st == ST_OK) ? chan_val[1:0]  : '0;
        rep.rate     = (st == ST_OK) ? rate_val[19:0] : '0;
        rep.bits     = (st == ST_OK) ? bits_val[4:0]  : '0;
        rep.payload  = (st == ST_OK) ? data_len[25:0] : '0;
        expected_reports.push_back(rep);
        parse_phase = PH_IDLE;
    endfunction

    function void take_byte(logic [7:0] b, logic first, logic eos);
        int unsigned p;
        status_t     st;
        if (first) begin
            reset_parser();
            parse_phase = PH_HEADER;
        end
        case (parse_phase)
            PH_IDLE: begin
            end
            PH_HEADER: begin
                p = byte_pos;
                if (p < 4) begin
                    if (b != RIFF_MAGIC[8*p +: 8]) riff_sig_ok = 1'b0;
                end else if (p < 8) begin
                    riff_len = le_insert(riff_len, p - 4, b);
                end else if (p < 16) begin
                    if (b != WAVEFMT_MAGIC[8*(p-8) +: 8]) wave_sig_ok = 1'b0;
                end else if (p < 20) begin
                    fmt_len = le_insert(fmt_len, p - 16, b);
                end else if (p < 22) begin
                    tag_val = le_insert(tag_val, p - 20, b);
                end else if (p < 24) begin
                    chan_val = le_insert(chan_val, p - 22, b);
                end else if (p < 28) begin
                    rate_val = le_insert(rate_val, p - 24, b);
                end else if (p >= 34 && p < 36) begin
                    bits_val = le_insert(bits_val, p - 34, b);
                end
                byte_pos = p + 1;
                if (p >= 35) begin
                    st = header_verdict();
                    if (st != ST_OK) begin
                        queue_report(st);
                        return;
                    end
                    ext_left    = (fmt_len > FMT_BASE) ? fmt_len - FMT_BASE : 0;
                    byte_pos    = 36;
                    data_sig_ok = 1'b1;
                    parse_phase = (ext_left > 0) ? PH_EXT : PH_TAIL;
                end
                if (eos) queue_report(ST_TRUNC);
            end
            PH_EXT: begin
                if (ext_left > 0) ext_left--;
                if (ext_left == 0) parse_phase = PH_TAIL;
                if (eos) queue_report(ST_TRUNC);
            end
            PH_TAIL: begin
                p = byte_pos;
                if (p < 36 || p > 43) p = 43;
                if (p < 40) begin
                    if (b != DATA_MAGIC[8*(p-36) +: 8]) data_sig_ok = 1'b0;
                end else begin
                    data_len = le_insert(data_len, p - 40, b);
                end
                byte_pos = p + 1;
                if (p == 43) begin
                    if (!data_sig_ok) queue_report(ST_DATA_SIG);
                    else if (data_len == 0 || data_len > SIZE_LIMIT) queue_report(ST_DATA_SIZE);
                    else queue_report(ST_OK);
                end else if (eos) begin
                    queue_report(ST_TRUNC);
                end
            end
        endcase
    endfunction

    function void check_report(logic [M_TDATA_W-1:0] d);
        wav_report_t want;
        if (expected_reports.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("[%0t] unexpected report: status %0d data %h", $realtime, d[3:0], d);
            return;
        end
        want = expected_reports.pop_front();
        checked++;
        if (want.status == ST_OK) ok_count++;
        if (d[3:0] !== want.status || d[5:4] !== want.channels || d[25:6] !== want.rate
                || d[30:26] !== want.bits || d[56:31] !== want.payload
                || d[M_TDATA_W-1:RES_W] !== '0) begin
            fails++;
            if (fails <= 10)
                $display("[%0t] report mismatch: expected status %0d ch %0d rate %0d",
                         $realtime, want.status, want.channels, want.rate,
                         " bits %0d bytes %0d,", want.bits, want.payload,
                         " got status %0d ch %0d rate %0d", d[3:0], d[5:4], d[25:6],
                         " bits %0d bytes %0d fill %h", d[30:26], d[56:31],
                         d[M_TDATA_W-1:RES_W]);
        end
    endfunction

    // A report enters the parser's output or skid register as its byte is taken, so the
    // result side is handled before the byte accepted at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_parser();
            expected_reports.delete();
        end else begin
            if (m_tvalid && m_tready) check_report(m_tdata);
            if (s_tvalid && s_tready) take_byte(s_tdata, s_tuser, s_tlast);
        end
        fail_count      <= fails;
        reports_waiting <= expected_reports.size();
        reports_checked <= checked;
        headers_ok      <= ok_count;
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top of the WAV header parser testbench: builds RIFF/WAVE byte streams, drives them into
// the parser with random gaps and back-pressure, and gives the verdict. Depends on whp_pkg,
// whp_checker and wav_header_parser.

module tb
    import whp_pkg::*;
();

    localparam int ITEM_TARGET    = 1500;  // input bytes in the whole run, roughly
    localparam int STALL_MAX      = 14;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    // One header as the generator sees it. The sig flags spoil one bit of a signature.
    typedef struct {
        logic [31:0] riff_sz;
        logic [31:0] fmt_sz;
        logic [15:0] tag;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] data_sz;
        logic        riff_bad;
        logic        wave_bad;
        logic        data_bad;
    } wav_hdr_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = '0;   // data_byte[7:0]
    logic                 s_tuser  = 1'b0; // first_byte
    logic                 s_tlast  = 1'b0; // end_of_stream
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // status, channel_count, sample_rate,
                                           // sample_bits, payload_bytes, zero fill

    int fail_count;
    int reports_waiting;
    int reports_checked;
    int headers_ok;

    int   item_count    = 0;
    int   ignored_count = 0;
    int   files_sent    = 0;
    logic tx_burst      = 1'b0;
    logic [7:0] file_bytes[$];

    wav_header_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    whp_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .reports_waiting (reports_waiting),
        .reports_checked (reports_checked),
        .headers_ok      (headers_ok)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: after every accepted report the receiver draws a random stall, possibly
    // none. Now and then it switches into a run where it never stalls, so that the
    // parser's output and skid registers also see a sink that keeps up.
    int rx_wait;
    int rx_draw;
    logic rx_burst;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
            rx_burst <= 1'b0;
        end else if (m_tready && m_tvalid) begin
            rx_draw = rx_burst ? 0 : $urandom_range(0, STALL_MAX);
            m_tready <= (rx_draw == 0);
            rx_wait  <= rx_draw;
            if ($urandom_range(0, 15) == 0) rx_burst <= ~rx_burst;
        end else if (!m_tready) begin
            m_tready <= (rx_wait <= 1);
            rx_wait  <= rx_wait - 1;
        end
    end

    // The watchdog counts cycles in which neither channel moves a transaction.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offers one byte on the input channel and returns once it has been taken. With no
    // gap drawn, tvalid simply stays high and only the payload changes.
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, STALL_MAX);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic void append_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
    endfunction

    // Lays out the canonical 44-byte header plus any format extension. The byte rate and
    // block align fields are not checked by the parser, so they carry random bytes.
    task automatic build_file(input wav_hdr_t h);
        int n_ext;
        int base;
        file_bytes.delete();
        append_le(RIFF_MAGIC, 4);
        append_le(h.riff_sz, 4);
        append_le(WAVEFMT_MAGIC[31:0], 4);
        append_le(WAVEFMT_MAGIC[63:32], 4);
        append_le(h.fmt_sz, 4);
        append_le(32'(h.tag), 2);
        append_le(32'(h.chans), 2);
        append_le(h.rate, 4);
        append_le($urandom, 4);
        append_le($urandom, 2);
        append_le(32'(h.bits), 2);
        // An oversized extension is rejected at the end of the fixed header, so a few
        // bytes beyond the limit are enough to keep such files short.
        n_ext = (h.fmt_sz > FMT_BASE && h.fmt_sz <= FMT_BASE + 24) ? h.fmt_sz - FMT_BASE : 0;
        for (int i = 0; i < n_ext; i++) file_bytes.push_back($urandom_range(0, 255));
        append_le(DATA_MAGIC, 4);
        append_le(h.data_sz, 4);
        base = file_bytes.size() - 8;
        if (h.riff_bad) begin
            base = $urandom_range(0, 3);
            file_bytes[base] = file_bytes[base] ^ (8'h01 << $urandom_range(0, 7));
            base = file_bytes.size() - 8;
        end
        if (h.wave_bad) begin
            n_ext = $urandom_range(8, 15);
            file_bytes[n_ext] = file_bytes[n_ext] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (h.data_bad) begin
            base = base + $urandom_range(0, 3);
            file_bytes[base] = file_bytes[base] ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    // Sends a file, cut short after 'cut' bytes when cut is positive and below its
    // length. The last byte sent carries end_of_stream when 'eos' is set. 'trailer' bytes
    // follow without the first-byte flag; the parser has to ignore them once it is idle.
    task automatic send_file(input wav_hdr_t h, input int cut, input logic eos,
                             input int trailer);
        int n;
        build_file(h);
        n = (cut > 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
        tx_burst = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n; i++)
            send_byte(file_bytes[i], i == 0, eos && i == n - 1);
        item_count += n;
        files_sent++;
        for (int i = 0; i < trailer; i++)
            send_byte($urandom_range(0, 255), 1'b0, $urandom_range(0, 9) == 0);
        ignored_count += trailer;
    endtask

    // Garbage that starts like a file; stray first-byte and end flags fall anywhere in it.
    task automatic send_noise(input int len);
        tx_burst = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++)
            send_byte($urandom_range(0, 255), i == 0 || $urandom_range(0, 29) == 0,
                      $urandom_range(0, 29) == 0);
        item_count += len;
        files_sent++;
    endtask

    function automatic wav_hdr_t good_hdr();
        wav_hdr_t h;
        h.riff_sz  = SIZE_MIN;
        h.fmt_sz   = FMT_BASE;
        h.tag      = TAG_PCM;
        h.chans    = CH_MONO;
        h.rate     = RATE_MIN;
        h.bits     = BITS_8;
        h.data_sz  = 32'd1;
        h.riff_bad = 1'b0;
        h.wave_bad = 1'b0;
        h.data_bad = 1'b0;
        return h;
    endfunction

    // Mostly inside [lo, hi], with the bounds themselves and the values just outside
    // them drawn often enough to matter.
    function automatic logic [31:0] range_value(logic [31:0] lo, logic [31:0] hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return lo - 1;
        if (r < 4) return hi + 1;
        if (r < 6) return $urandom;
        if (r < 11) return lo;
        if (r < 16) return hi;
        return $urandom_range(lo, hi);
    endfunction

    // Roughly half of the random headers come out fully valid; the rest break one or a
    // few checks so that the error priority gets exercised too.
    function automatic wav_hdr_t random_hdr();
        wav_hdr_t h;
        int r;
        h.riff_sz = range_value(SIZE_MIN, SIZE_LIMIT);
        h.rate    = range_value(RATE_MIN, RATE_MAX);
        h.data_sz = range_value(32'd1, SIZE_LIMIT);
        r = $urandom_range(0, 99);
        if (r < 50)      h.fmt_sz = FMT_BASE;
        else if (r < 75) h.fmt_sz = $urandom_range(17, 36);
        else if (r < 80) h.fmt_sz = FMT_BASE + MAX_EXTENSION_DEFAULT;
        else if (r < 88) h.fmt_sz = $urandom_range(0, 15);
        else if (r < 94) h.fmt_sz = $urandom_range(37, 40);
        else             h.fmt_sz = $urandom;
        h.tag = ($urandom_range(0, 99) < 94) ? TAG_PCM : 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 46)      h.chans = CH_MONO;
        else if (r < 92) h.chans = CH_STEREO;
        else if (r < 96) h.chans = 16'($urandom_range(0, 1) * 3);
        else             h.chans = 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 46)      h.bits = BITS_8;
        else if (r < 92) h.bits = BITS_16;
        else             h.bits = 16'($urandom_range(0, 65535));
        h.riff_bad = ($urandom_range(0, 99) < 4);
        h.wave_bad = ($urandom_range(0, 99) < 4);
        h.data_bad = ($urandom_range(0, 99) < 4);
        return h;
    endfunction

    initial begin
        wav_hdr_t h;
        int r;

        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Bytes before any file has started must vanish without a report.
        send_byte(8'h52, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        ignored_count += 3;

        // Lowest legal values, end_of_stream on the final data size byte.
        h = good_hdr();
        send_file(h, 0, 1'b1, 2);
        // Highest legal values and the longest extension that is still accepted.
        h = good_hdr();
        h.riff_sz = SIZE_LIMIT; h.fmt_sz = FMT_BASE + MAX_EXTENSION_DEFAULT;
        h.chans = CH_STEREO; h.rate = RATE_MAX; h.bits = BITS_16; h.data_sz = SIZE_LIMIT;
        send_file(h, 0, 1'b0, 0);
        // A format chunk shorter than 16 bytes has no extension to skip.
        h = good_hdr(); h.fmt_sz = 32'd15;
        send_file(h, 0, 1'b0, 0);

        // Each header check in turn, several paired with a later one to show priority.
        h = good_hdr(); h.riff_bad = 1'b1; h.rate = RATE_MIN - 1;
        send_file(h, 0, 1'b0, 0);
        h = good_hdr(); h.wave_bad = 1'b1; h.riff_sz = SIZE_MIN - 1;
        send_file(h, 0, 1'b0, 0);
        h = good_hdr(); h.riff_sz = SIZE_LIMIT + 1; h.tag = 16'd0;
        send_file(h, 0, 1'b0, 0);
        h = good_hdr(); h.tag = 16'd2; h.chans = 16'd3;
        send_file(h, 0, 1'b0, 0);
        h = good_hdr(); h.chans = 16'd0;
        send_file(h, 0, 1'b0, 0);
        h = good_hdr(); h.rate = RATE_MAX + 1; h.bits = 16'd7;
        send_file(h, 0, 1'b0, 0);
        h = good_hdr(); h.bits = 16'hFFFF; h.fmt_sz = FMT_BASE + MAX_EXTENSION_DEFAULT + 1;
        send_file(h, 0, 1'b0, 0);
        h = good_hdr(); h.fmt_sz = FMT_BASE + MAX_EXTENSION_DEFAULT + 1;
        send_file(h, 0, 1'b0, 0);
        // A huge format size must be judged as an unsigned length.
        h = good_hdr(); h.fmt_sz = 32'hFFFF_FFFF;
        send_file(h, 0, 1'b0, 0);

        // Tail checks: the data signature goes ahead of the data size.
        h = good_hdr(); h.data_bad = 1'b1; h.data_sz = 32'd0;
        send_file(h, 0, 1'b0, 0);
        h = good_hdr(); h.data_sz = 32'd0;
        send_file(h, 0, 1'b0, 0);
        h = good_hdr(); h.data_sz = SIZE_LIMIT + 1;
        send_file(h, 0, 1'b1, 0);

        // Streams that end early: on the very first byte, on the last fixed header byte
        // with a clean header and with a bad one, inside the extension and in the tail.
        h = good_hdr();
        send_file(h, 1, 1'b1, 0);
        h = good_hdr();
        send_file(h, 36, 1'b1, 0);
        h = good_hdr(); h.bits = 16'd9;
        send_file(h, 36, 1'b1, 0);
        h = good_hdr(); h.fmt_sz = 32'd20;
        send_file(h, 38, 1'b1, 0);
        h = good_hdr();
        send_file(h, 43, 1'b1, 0);

        // A file abandoned halfway, then restarted by the next first byte.
        h = good_hdr();
        send_file(h, 20, 1'b0, 0);
        h = good_hdr(); h.chans = CH_STEREO; h.bits = BITS_16;
        send_file(h, 0, 1'b1, 3);

        // Random part: mostly complete headers with random content, the rest cut short,
        // abandoned mid-file or plain noise.
        while (item_count + ignored_count < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            h = random_hdr();
            if (r < 70)
                send_file(h, 0, $urandom_range(0, 1), $urandom_range(0, 3));
            else if (r < 82)
                send_file(h, $urandom_range(1, 43), 1'b1, $urandom_range(0, 2));
            else if (r < 90)
                send_file(h, $urandom_range(1, 43), 1'b0, 0);
            else
                send_noise($urandom_range(1, 60));
        end
        s_tvalid <= 1'b0;

        // Let the checker see the last byte, wait for every report, then give a late or
        // surplus report time to show up.
        @(posedge aclk);
        while (reports_waiting != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Streamed %0d files: %0d header bytes plus %0d bytes the parser had to ignore.",
                 files_sent, item_count, ignored_count);
        $display("Checked %0d reports, %0d of them accepted headers; %0d failures.",
                 reports_checked, headers_ok, fail_count);
        if (fail_count == 0 && reports_waiting == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
